@@ rtl/grid_astar_path_search_core_macros.svh @@
// Assertion macros for the checker file of the path search core.
`ifndef GRID_ASTAR_PATH_SEARCH_CORE_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gaps_pkg.sv @@
package gaps_pkg;

    // Map geometry.
    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = $clog2(GRID_SIDE);
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int COUNT_W   = CELL_W + 1;

    // Fixed point costs with 8 fraction bits.
    localparam int                COST_W        = 21;
    localparam logic [COST_W-1:0] COST_MAX      = '1;
    localparam logic [COST_W-1:0] STEP_STRAIGHT = COST_W'(256);
    localparam logic [COST_W-1:0] STEP_DIAGONAL = COST_W'(362);

    // Heuristic square root: radicand is (dr*dr + dc*dc) << 16.
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int RAD_W   = SQ_W + 16;
    localparam int BIT_TOP = ((RAD_W - 1) % 2 == 0) ? RAD_W - 1 : RAD_W - 2;

    // Per-cell search marks.
    localparam int              MARK_W      = 2;
    localparam logic [MARK_W-1:0] MARK_NONE   = 2'b00;
    localparam logic [MARK_W-1:0] MARK_OPEN   = 2'b01;
    localparam logic [MARK_W-1:0] MARK_CLOSED = 2'b10;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_OUT_OF_MAP  = 3'd1,
        STS_BLOCKED     = 3'd2,
        STS_SAME_CELL   = 3'd3,
        STS_NO_PATH     = 3'd4,
        STS_BEYOND_PATH = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_FREE_GOAL,
        ST_FREE_CHK,
        ST_MARK_CLR,
        ST_START_H,
        ST_START_HW,
        ST_SEL,
        ST_REMOVE,
        ST_POP,
        ST_EXP_G,
        ST_EXP_DIR,
        ST_EXP_CHK,
        ST_EXP_H,
        ST_PATH_COST,
        ST_PATH_STEP,
        ST_PATH_WAIT,
        ST_READ_WAIT
    } t_state;

    // Row step of a neighbour direction, row-major order of the eight deltas.
    function automatic logic signed [1:0] dir_row(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            3'd0, 3'd1, 3'd2: r = -2'sd1;
            3'd3, 3'd4:       r = 2'sd0;
            default:          r = 2'sd1;
        endcase
        return r;
    endfunction

    // Column step of a neighbour direction.
    function automatic logic signed [1:0] dir_col(input logic [2:0] d);
        logic signed [1:0] c;
        case (d)
            3'd0, 3'd3, 3'd5: c = -2'sd1;
            3'd1, 3'd6:       c = 2'sd0;
            default:          c = 2'sd1;
        endcase
        return c;
    endfunction

    // Saturating cost addition.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

@@ rtl/grid_astar_path_search_core.sv @@
// A* path search core over a 64 x 64 map of free and blocked cells. An item is
// taken when start is high and busy is low; its one result shows on the result
// ports for a single cycle with o_done high, and the receiver cannot hold it off.
// After reset the core blocks every map cell, busy high. A search first clears
// the marks of every cell (one cell per cycle), then per expanded cell scans the
// open list for the lowest f, closes the gap left by the chosen entry, and makes
// up to 8 neighbour checks; for every neighbour whose cost improves it waits on
// the shared one-digit-per-cycle square root unit of the heuristic. The path
// walk then follows parents back from the goal to the start.
// The diagonal-move register is written over its own valid/ready channel.
module grid_astar_path_search_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_action,
    input  logic [5:0]                   i_cell_row,
    input  logic [5:0]                   i_cell_col,
    input  logic                         i_cell_free,
    input  logic [5:0]                   i_goal_row,
    input  logic [5:0]                   i_goal_col,
    input  logic [11:0]                  i_path_index,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic                         o_path_found,
    output logic [12:0]                  o_path_length,
    output logic [20:0]                  o_path_cost,
    output logic [5:0]                   o_out_row,
    output logic [5:0]                   o_out_col,
    output logic                         o_last_entry,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);
    import gaps_pkg::*;

    // Control state.
    t_state             r_state, n_state;
    logic               r_done, n_done;
    logic               r_eight, n_eight;
    logic               r_found, n_found;
    logic [COUNT_W-1:0] r_path_count, n_path_count;
    logic [COST_W-1:0]  r_found_cost, n_found_cost;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_p1v, n_p1v, r_p2v, n_p2v;

    // Datapath registers.
    t_action            r_act, n_act;
    logic [COORD_W-1:0] r_srow, n_srow, r_scol, n_scol, r_grow, n_grow, r_gcol, n_gcol;
    logic               r_cfree, n_cfree;
    logic [CELL_W-1:0]  r_idx, n_idx;
    t_status            r_status, n_status;
    logic [COORD_W-1:0] r_orow, n_orow, r_ocol, n_ocol;
    logic               r_last, n_last;
    logic               r_sfree, n_sfree;
    logic [CELL_W-1:0]  r_addr, n_addr;
    logic [COUNT_W-1:0] r_i, n_i;
    logic [CELL_W-1:0]  r_p1pos, n_p1pos, r_p2pos, n_p2pos;
    logic [CELL_W-1:0]  r_p2cell, n_p2cell;
    logic [CELL_W-1:0]  r_best_pos, n_best_pos, r_best_cell, n_best_cell;
    logic [COST_W-1:0]  r_best_f, n_best_f;
    logic [COST_W-1:0]  r_gcur, n_gcur, r_tg, n_tg, r_fcost, n_fcost;
    logic [3:0]         r_d, n_d;
    logic [CELL_W-1:0]  r_nb, n_nb, r_p, n_p;
    logic [COUNT_W-1:0] r_pn, n_pn;

    // Memory ports.
    logic                free_we, mark_we, cost_we, fest_we, par_we, ol_we, path_we;
    logic [CELL_W-1:0]   free_wa, mark_wa, cost_wa, fest_wa, par_wa, ol_wa, path_wa;
    logic [CELL_W-1:0]   free_ra, mark_ra, cost_ra, fest_ra, par_ra, ol_ra, path_ra;
    logic                free_wd, free_rd;
    logic [MARK_W-1:0]   mark_wd, mark_rd;
    logic [COST_W-1:0]   cost_wd, cost_rd, fest_wd, fest_rd;
    logic [2:0]          par_wd, par_rd;
    logic [CELL_W-1:0]   ol_wd, ol_rd, path_wd, path_rd;

    // Heuristic unit.
    logic               h_start, h_done;
    logic [COORD_W-1:0] h_row, h_col;
    logic [COST_W-1:0]  h_val;

    // Neighbour and parent arithmetic.
    logic signed [COORD_W+1:0] nb_r, nb_c, pa_r, pa_c;
    logic                      nb_in, pa_in, diag;
    logic [COST_W-1:0]         tg;
    logic [CELL_W-1:0]         start_cell, goal_cell;

    gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_free_ram (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_wa), .i_wdata(free_wd),
        .i_raddr(free_ra), .o_rdata(free_rd));
    gaps_ram #(.WIDTH(MARK_W), .DEPTH(CELLS)) u_mark_ram (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(mark_wa), .i_wdata(mark_wd),
        .i_raddr(mark_ra), .o_rdata(mark_rd));
    gaps_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost_ram (
        .i_clk(i_clk), .i_we(cost_we), .i_waddr(cost_wa), .i_wdata(cost_wd),
        .i_raddr(cost_ra), .o_rdata(cost_rd));
    gaps_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_fest_ram (
        .i_clk(i_clk), .i_we(fest_we), .i_waddr(fest_wa), .i_wdata(fest_wd),
        .i_raddr(fest_ra), .o_rdata(fest_rd));
    gaps_ram #(.WIDTH(3), .DEPTH(CELLS)) u_par_ram (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(par_ra), .o_rdata(par_rd));
    gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_open_ram (
        .i_clk(i_clk), .i_we(ol_we), .i_waddr(ol_wa), .i_wdata(ol_wd),
        .i_raddr(ol_ra), .o_rdata(ol_rd));
    gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path_ram (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_wa), .i_wdata(path_wd),
        .i_raddr(path_ra), .o_rdata(path_rd));

    gaps_hsqrt u_hsqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(h_start),
        .i_row(h_row), .i_col(h_col), .i_goal_row(r_grow), .i_goal_col(r_gcol),
        .o_done(h_done), .o_h(h_val));

    // Neighbour of the expanded cell, parent of the path cell, tentative cost.
    always_comb begin
        start_cell = {r_srow, r_scol};
        goal_cell  = {r_grow, r_gcol};
        diag = (dir_row(r_d[2:0]) != 2'sd0) && (dir_col(r_d[2:0]) != 2'sd0);
        nb_r = $signed({2'b00, r_best_cell[CELL_W-1:COORD_W]})
             + (COORD_W+2)'(dir_row(r_d[2:0]));
        nb_c = $signed({2'b00, r_best_cell[COORD_W-1:0]})
             + (COORD_W+2)'(dir_col(r_d[2:0]));
        nb_in = (nb_r >= 0) && (nb_r < GRID_SIDE) && (nb_c >= 0) && (nb_c < GRID_SIDE);
        pa_r = $signed({2'b00, r_p[CELL_W-1:COORD_W]}) - (COORD_W+2)'(dir_row(par_rd));
        pa_c = $signed({2'b00, r_p[COORD_W-1:0]}) - (COORD_W+2)'(dir_col(par_rd));
        pa_in = (pa_r >= 0) && (pa_r < GRID_SIDE) && (pa_c >= 0) && (pa_c < GRID_SIDE);
        tg = sat_add(r_gcur, diag ? STEP_DIAGONAL : STEP_STRAIGHT);
    end

    // Sequencer: next state, memory ports and result.
    always_comb begin
        n_state = r_state;      n_done = 1'b0;          n_eight = r_eight;
        n_found = r_found;      n_path_count = r_path_count;
        n_found_cost = r_found_cost;  n_count = r_count;
        n_p1v = 1'b0;           n_p2v = 1'b0;
        n_act = r_act;          n_srow = r_srow;        n_scol = r_scol;
        n_grow = r_grow;        n_gcol = r_gcol;        n_cfree = r_cfree;
        n_idx = r_idx;          n_status = r_status;    n_orow = r_orow;
        n_ocol = r_ocol;        n_last = r_last;        n_sfree = r_sfree;
        n_addr = r_addr;        n_i = r_i;              n_p1pos = r_p1pos;
        n_p2pos = r_p2pos;      n_p2cell = r_p2cell;    n_best_pos = r_best_pos;
        n_best_cell = r_best_cell;    n_best_f = r_best_f;
        n_gcur = r_gcur;        n_tg = r_tg;            n_fcost = r_fcost;
        n_d = r_d;              n_nb = r_nb;            n_p = r_p;
        n_pn = r_pn;

        free_we = 1'b0; free_wa = '0; free_wd = 1'b0; free_ra = '0;
        mark_we = 1'b0; mark_wa = '0; mark_wd = MARK_NONE; mark_ra = '0;
        cost_we = 1'b0; cost_wa = '0; cost_wd = '0; cost_ra = '0;
        fest_we = 1'b0; fest_wa = '0; fest_wd = '0; fest_ra = '0;
        par_we  = 1'b0; par_wa  = '0; par_wd  = '0; par_ra  = '0;
        ol_we   = 1'b0; ol_wa   = '0; ol_wd   = '0; ol_ra   = '0;
        path_we = 1'b0; path_wa = '0; path_wd = '0; path_ra = '0;
        h_start = 1'b0; h_row = r_srow; h_col = r_scol;

        // Register transfer on the configuration channel.
        if (i_cfg_valid) begin
            n_eight = i_cfg_data;
        end

        unique case (r_state)
            // Block every map cell and clear every mark after reset.
            ST_CLEAR: begin
                free_we = 1'b1; free_wa = r_addr; free_wd = 1'b0;
                mark_we = 1'b1; mark_wa = r_addr; mark_wd = MARK_NONE;
                n_addr = r_addr + 1'b1;
                if (&r_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_act = t_action'(i_action);
                    n_srow = i_cell_row;  n_scol = i_cell_col;  n_cfree = i_cell_free;
                    n_grow = i_goal_row;  n_gcol = i_goal_col;  n_idx = i_path_index;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_status = STS_OK; n_orow = '0; n_ocol = '0; n_last = 1'b0;
                unique case (r_act)
                    ACT_WRITE: begin
                        if (int'(r_srow) < GRID_SIDE && int'(r_scol) < GRID_SIDE) begin
                            free_we = 1'b1; free_wa = start_cell; free_wd = r_cfree;
                        end else begin
                            n_status = STS_OUT_OF_MAP;
                        end
                        n_done = 1'b1; n_state = ST_IDLE;
                    end
                    ACT_SEARCH: begin
                        if (int'(r_srow) < GRID_SIDE && int'(r_scol) < GRID_SIDE &&
                            int'(r_grow) < GRID_SIDE && int'(r_gcol) < GRID_SIDE) begin
                            free_ra = start_cell;
                            n_state = ST_FREE_GOAL;
                        end else begin
                            n_found = 1'b0; n_path_count = '0; n_found_cost = '0;
                            n_status = STS_OUT_OF_MAP; n_done = 1'b1; n_state = ST_IDLE;
                        end
                    end
                    ACT_READ: begin
                        if ({1'b0, r_idx} < r_path_count) begin
                            path_ra = r_idx;
                            n_state = ST_READ_WAIT;
                        end else begin
                            n_status = STS_BEYOND_PATH; n_done = 1'b1; n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        n_done = 1'b1; n_state = ST_IDLE;
                    end
                endcase
            end
            ST_READ_WAIT: begin
                n_orow = path_rd[CELL_W-1:COORD_W];
                n_ocol = path_rd[COORD_W-1:0];
                n_last = ({1'b0, r_idx} + 1'b1) == r_path_count;
                n_done = 1'b1; n_state = ST_IDLE;
            end
            // Start and goal must be free and distinct.
            ST_FREE_GOAL: begin
                free_ra = goal_cell;
                n_sfree = free_rd;
                n_state = ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
                if (!r_sfree || !free_rd || start_cell == goal_cell) begin
                    n_found = 1'b0; n_path_count = '0; n_found_cost = '0;
                    n_status = (!r_sfree || !free_rd) ? STS_BLOCKED : STS_SAME_CELL;
                    n_done = 1'b1; n_state = ST_IDLE;
                end else begin
                    n_addr = '0; n_state = ST_MARK_CLR;
                end
            end
            ST_MARK_CLR: begin
                mark_we = 1'b1; mark_wa = r_addr; mark_wd = MARK_NONE;
                n_addr = r_addr + 1'b1;
                if (&r_addr) begin
                    n_state = ST_START_H;
                end
            end
            ST_START_H: begin
                h_start = 1'b1;
                n_state = ST_START_HW;
            end
            // Seed the open list with the start cell.
            ST_START_HW: begin
                if (h_done) begin
                    cost_we = 1'b1; cost_wa = start_cell; cost_wd = '0;
                    fest_we = 1'b1; fest_wa = start_cell; fest_wd = h_val;
                    mark_we = 1'b1; mark_wa = start_cell; mark_wd = MARK_OPEN;
                    ol_we = 1'b1; ol_wa = '0; ol_wd = start_cell;
                    n_count = COUNT_W'(1);
                    n_i = '0; n_state = ST_SEL;
                end
            end
            // Scan the open list for the lowest f; a later tie wins.
            ST_SEL: begin
                if (r_count == '0) begin
                    n_found = 1'b0; n_path_count = '0; n_found_cost = '0;
                    n_status = STS_NO_PATH; n_done = 1'b1; n_state = ST_IDLE;
                end else begin
                    if (r_i < r_count) begin
                        ol_ra = r_i[CELL_W-1:0];
                        n_p1v = 1'b1; n_p1pos = r_i[CELL_W-1:0];
                        n_i = r_i + 1'b1;
                    end
                    if (r_p1v) begin
                        fest_ra = ol_rd;
                        n_p2v = 1'b1; n_p2pos = r_p1pos; n_p2cell = ol_rd;
                    end
                    if (r_p2v && (r_p2pos == '0 || fest_rd <= r_best_f)) begin
                        n_best_pos = r_p2pos; n_best_cell = r_p2cell; n_best_f = fest_rd;
                    end
                    if (r_i == r_count && !r_p1v && !r_p2v) begin
                        n_i = {1'b0, r_best_pos} + 1'b1;
                        n_state = ST_REMOVE;
                    end
                end
            end
            // Close the gap left by the chosen entry, keeping list order.
            ST_REMOVE: begin
                if (r_i < r_count) begin
                    ol_ra = r_i[CELL_W-1:0];
                    n_p1v = 1'b1; n_p1pos = r_i[CELL_W-1:0];
                    n_i = r_i + 1'b1;
                end
                if (r_p1v) begin
                    ol_we = 1'b1; ol_wa = r_p1pos - 1'b1; ol_wd = ol_rd;
                end
                if (r_i >= r_count && !r_p1v) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                mark_we = 1'b1; mark_wa = r_best_cell; mark_wd = MARK_CLOSED;
                n_count = r_count - 1'b1;
                if (r_best_cell == goal_cell) begin
                    path_we = 1'b1; path_wa = '0; path_wd = goal_cell;
                    n_p = goal_cell; n_pn = COUNT_W'(1);
                    cost_ra = goal_cell;
                    n_state = ST_PATH_COST;
                end else begin
                    cost_ra = r_best_cell;
                    n_state = ST_EXP_G;
                end
            end
            ST_EXP_G: begin
                n_gcur = cost_rd; n_d = '0;
                n_state = ST_EXP_DIR;
            end
            // Visit neighbours in row-major delta order.
            ST_EXP_DIR: begin
                if (r_d[3]) begin
                    n_i = '0; n_state = ST_SEL;
                end else if ((diag && !r_eight) || !nb_in) begin
                    n_d = r_d + 1'b1;
                end else begin
                    n_nb = {nb_r[COORD_W-1:0], nb_c[COORD_W-1:0]};
                    free_ra = {nb_r[COORD_W-1:0], nb_c[COORD_W-1:0]};
                    mark_ra = {nb_r[COORD_W-1:0], nb_c[COORD_W-1:0]};
                    cost_ra = {nb_r[COORD_W-1:0], nb_c[COORD_W-1:0]};
                    n_state = ST_EXP_CHK;
                end
            end
            ST_EXP_CHK: begin
                n_d = r_d + 1'b1;
                n_state = ST_EXP_DIR;
                if (free_rd && !mark_rd[1]) begin
                    if ((!mark_rd[0] && r_count < CELLS) ||
                        (mark_rd[0] && tg < cost_rd)) begin
                        if (!mark_rd[0]) begin
                            mark_we = 1'b1; mark_wa = r_nb; mark_wd = MARK_OPEN;
                            ol_we = 1'b1; ol_wa = r_count[CELL_W-1:0]; ol_wd = r_nb;
                            n_count = r_count + 1'b1;
                        end
                        cost_we = 1'b1; cost_wa = r_nb; cost_wd = tg;
                        par_we = 1'b1; par_wa = r_nb; par_wd = r_d[2:0];
                        n_tg = tg;
                        h_start = 1'b1;
                        h_row = r_nb[CELL_W-1:COORD_W]; h_col = r_nb[COORD_W-1:0];
                        n_d = r_d;
                        n_state = ST_EXP_H;
                    end
                end
            end
            ST_EXP_H: begin
                if (h_done) begin
                    fest_we = 1'b1; fest_wa = r_nb; fest_wd = sat_add(r_tg, h_val);
                    n_d = r_d + 1'b1;
                    n_state = ST_EXP_DIR;
                end
            end
            // Walk parents from the goal back to the start.
            ST_PATH_COST: begin
                n_fcost = cost_rd;
                n_state = ST_PATH_STEP;
            end
            ST_PATH_STEP: begin
                if (r_p == start_cell || r_pn >= CELLS) begin
                    n_found = 1'b1; n_path_count = r_pn; n_found_cost = r_fcost;
                    n_done = 1'b1; n_state = ST_IDLE;
                end else begin
                    par_ra = r_p;
                    n_state = ST_PATH_WAIT;
                end
            end
            ST_PATH_WAIT: begin
                if (!pa_in) begin
                    n_found = 1'b1; n_path_count = r_pn; n_found_cost = r_fcost;
                    n_done = 1'b1; n_state = ST_IDLE;
                end else begin
                    path_we = 1'b1; path_wa = r_pn[CELL_W-1:0];
                    path_wd = {pa_r[COORD_W-1:0], pa_c[COORD_W-1:0]};
                    n_p = {pa_r[COORD_W-1:0], pa_c[COORD_W-1:0]};
                    n_pn = r_pn + 1'b1;
                    n_state = ST_PATH_STEP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_done <= 1'b0;
            r_eight <= 1'b1;
            r_found <= 1'b0;
            r_path_count <= '0;
            r_found_cost <= '0;
            r_count <= '0;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_addr <= '0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
            r_eight <= n_eight;
            r_found <= n_found;
            r_path_count <= n_path_count;
            r_found_cost <= n_found_cost;
            r_count <= n_count;
            r_p1v <= n_p1v;
            r_p2v <= n_p2v;
            r_addr <= n_addr;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_act <= n_act;     r_srow <= n_srow;   r_scol <= n_scol;
        r_grow <= n_grow;   r_gcol <= n_gcol;   r_cfree <= n_cfree;
        r_idx <= n_idx;     r_status <= n_status;
        r_orow <= n_orow;   r_ocol <= n_ocol;   r_last <= n_last;
        r_sfree <= n_sfree; r_i <= n_i;         r_p1pos <= n_p1pos;
        r_p2pos <= n_p2pos; r_p2cell <= n_p2cell;
        r_best_pos <= n_best_pos; r_best_cell <= n_best_cell; r_best_f <= n_best_f;
        r_gcur <= n_gcur;   r_tg <= n_tg;       r_fcost <= n_fcost;
        r_d <= n_d;         r_nb <= n_nb;       r_p <= n_p;
        r_pn <= n_pn;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_path_found  = r_found;
    assign o_path_length = r_path_count;
    assign o_path_cost   = r_found_cost;
    assign o_out_row     = r_orow;
    assign o_out_col     = r_ocol;
    assign o_last_entry  = r_last;

endmodule

@@ rtl/gaps_ram.sv @@
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/gaps_hsqrt.sv @@
module gaps_hsqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gaps_pkg::COORD_W-1:0]  i_row,
    input  logic [gaps_pkg::COORD_W-1:0]  i_col,
    input  logic [gaps_pkg::COORD_W-1:0]  i_goal_row,
    input  logic [gaps_pkg::COORD_W-1:0]  i_goal_col,
    output logic                          o_done,
    output logic [gaps_pkg::COST_W-1:0]   o_h
);
    import gaps_pkg::*;

    logic             r_busy, r_done;
    logic [RAD_W-1:0] r_v, r_res, r_bit;
    logic [COORD_W-1:0] dr, dc;
    logic [SQ_W-1:0]    sq_sum;
    logic [RAD_W:0]     trial;

    // Distances and their squared sum, registered before the root iterations.
    always_comb begin
        dr     = (i_row > i_goal_row) ? i_row - i_goal_row : i_goal_row - i_row;
        dc     = (i_col > i_goal_col) ? i_col - i_goal_col : i_goal_col - i_col;
        sq_sum = SQ_W'(dr * dr) + SQ_W'(dc * dc);
        trial  = {1'b0, r_res} + {1'b0, r_bit};
    end

    // Control: one root digit per cycle until the lowest bit has been tried.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Bitwise integer square root datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= {sq_sum, 16'd0};
            r_res <= '0;
            r_bit <= RAD_W'(1) << BIT_TOP;
        end else if (r_busy) begin
            if ({1'b0, r_v} >= trial) begin
                r_v   <= r_v - trial[RAD_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_h    = (|r_res[RAD_W-1:COST_W]) ? COST_MAX : r_res[COST_W-1:0];

endmodule

@@ rtl/gaps_chk.sv @@
`include "grid_astar_path_search_core_macros.svh"

module gaps_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [2:0] o_status,
    input logic       o_path_found,
    input logic [5:0] o_out_row,
    input logic [5:0] o_out_col,
    input logic       o_last_entry
);
    import gaps_pkg::*;

    // An accepted item keeps the core busy in the following cycle.
    `GAPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")

    // Each result is a single-cycle strobe.
    `GAPS_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe held")

    // A read beyond the path carries no cell.
    `GAPS_ASSERT_IMP(a_beyond_empty, i_clk, i_rst_n, o_done && o_status == STS_BEYOND_PATH, o_out_row == 6'd0 && o_out_col == 6'd0 && !o_last_entry, "cell on failed read")

    // The start cell can only be read back from a found path.
    `GAPS_ASSERT_IMP(a_last_needs_path, i_clk, i_rst_n, o_done && o_last_entry, o_path_found, "last entry without path")

endmodule

bind grid_astar_path_search_core gaps_chk u_gaps_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_status(o_status), .o_path_found(o_path_found), .o_out_row(o_out_row),
    .o_out_col(o_out_col), .o_last_entry(o_last_entry));

@@ verif/grid_astar_path_search_core_test.sv @@
`default_nettype none

module grid_astar_path_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gaps_pkg::*;

    localparam int SIDE        = 64;
    localparam int NCELLS      = SIDE * SIDE;
    localparam int UNIT        = 256;
    localparam int DIAG        = 362;
    localparam int COST_TOP    = 2097151;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int REGION      = 6;

    // Row-major neighbor deltas, from the parent to the child.
    localparam int NB_DR [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    localparam int NB_DC [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    typedef struct {
        t_action     action;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        free;
        logic [5:0]  goal_row;
        logic [5:0]  goal_col;
        logic [11:0] index;
        bit          drain;
    } t_cmd;

    typedef struct {
        t_status     status;
        logic        found;
        logic [12:0] length;
        logic [20:0] cost;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [5:0]  i_cell_row;
    logic [5:0]  i_cell_col;
    logic        i_cell_free;
    logic [5:0]  i_goal_row;
    logic [5:0]  i_goal_col;
    logic [11:0] i_path_index;
    logic        o_done;
    logic [2:0]  o_status;
    logic        o_path_found;
    logic [12:0] o_path_length;
    logic [20:0] o_path_cost;
    logic [5:0]  o_out_row;
    logic [5:0]  o_out_col;
    logic        o_last_entry;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    grid_astar_path_search_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_cell_free   (i_cell_free),
        .i_goal_row    (i_goal_row),
        .i_goal_col    (i_goal_col),
        .i_path_index  (i_path_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_path_found  (o_path_found),
        .o_path_length (o_path_length),
        .o_path_cost   (o_path_cost),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_entry  (o_last_entry),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow state of the search core.
    bit          diag_moves;
    bit          map_free   [NCELLS];
    int unsigned g_cost     [NCELLS];
    int unsigned f_cost     [NCELLS];
    int          came_from  [NCELLS];
    bit          is_open    [NCELLS];
    bit          is_closed  [NCELLS];
    int          frontier   [NCELLS];
    int          frontier_n;
    int          route      [NCELLS];
    int          route_n;
    bit          route_found;
    int unsigned route_cost;

    t_cmd   pending_cmds [$];
    t_reply expected_replies [$];
    bit     plan_free [REGION][REGION];
    int     max_gap;
    int     gap_left;
    t_cmd   cur_cmd;
    bit     taken;
    int     cycles;
    int     errors;
    int     routes_ok;
    int     routes_none;
    int     reads_ok;

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned cost_add(int unsigned a, int unsigned b);
        return (a + b > COST_TOP) ? COST_TOP : a + b;
    endfunction

    // Euclidean distance to the goal with 8 fraction bits.
    function automatic int unsigned dist_to_goal(int r, int c, int gr, int gc);
        longint unsigned dr;
        longint unsigned dc;
        longint unsigned h;
        dr = (r > gr) ? r - gr : gr - r;
        dc = (c > gc) ? c - gc : gc - c;
        h  = root_floor((dr * dr + dc * dc) << 16);
        return (h > COST_TOP) ? COST_TOP : int'(h);
    endfunction

    function automatic void drop_route();
        route_found = 0;
        route_n     = 0;
        route_cost  = 0;
    endfunction

    // A* over the shadow map; the goal-to-start path is kept for later reads.
    function automatic t_status plan_route(int sr, int sc, int gr, int gc);
        int src;
        int dst;
        int best;
        int cur;
        int nr;
        int nc;
        int nb;
        int p;
        int pd;
        int unsigned tg;
        bit straight;
        src = sr * SIDE + sc;
        dst = gr * SIDE + gc;
        if (!map_free[src] || !map_free[dst]) begin
            drop_route();
            return STS_BLOCKED;
        end
        if (src == dst) begin
            drop_route();
            return STS_SAME_CELL;
        end
        foreach (is_open[i]) begin
            is_open[i]   = 0;
            is_closed[i] = 0;
        end
        g_cost[src]  = 0;
        f_cost[src]  = dist_to_goal(sr, sc, gr, gc);
        is_open[src] = 1;
        frontier[0]  = src;
        frontier_n   = 1;
        while (frontier_n > 0) begin
            // Lowest f wins; on a tie the later entry wins.
            best = 0;
            for (int i = 1; i < frontier_n; i++)
                if (f_cost[frontier[i]] <= f_cost[frontier[best]]) best = i;
            cur = frontier[best];
            for (int i = best; i + 1 < frontier_n; i++) frontier[i] = frontier[i + 1];
            frontier_n--;
            is_open[cur]   = 0;
            is_closed[cur] = 1;
            if (cur == dst) begin
                p = dst;
                route_n = 0;
                route[route_n++] = p;
                while (p != src && route_n < NCELLS) begin
                    pd = came_from[p];
                    nr = p / SIDE - NB_DR[pd];
                    nc = p % SIDE - NB_DC[pd];
                    if (nr < 0 || nc < 0 || nr >= SIDE || nc >= SIDE) break;
                    p = nr * SIDE + nc;
                    route[route_n++] = p;
                end
                route_found = 1;
                route_cost  = g_cost[dst];
                return STS_OK;
            end
            for (int d = 0; d < 8; d++) begin
                straight = (NB_DR[d] == 0) || (NB_DC[d] == 0);
                if (!straight && !diag_moves) continue;
                nr = cur / SIDE + NB_DR[d];
                nc = cur % SIDE + NB_DC[d];
                if (nr < 0 || nc < 0 || nr >= SIDE || nc >= SIDE) continue;
                nb = nr * SIDE + nc;
                if (!map_free[nb] || is_closed[nb]) continue;
                tg = cost_add(g_cost[cur], straight ? UNIT : DIAG);
                if (!is_open[nb]) begin
                    if (frontier_n >= NCELLS) continue;
                    is_open[nb] = 1;
                    frontier[frontier_n++] = nb;
                end else if (tg >= g_cost[nb]) begin
                    continue;
                end
                g_cost[nb]    = tg;
                f_cost[nb]    = cost_add(tg, dist_to_goal(nr, nc, gr, gc));
                came_from[nb] = d;
            end
        end
        drop_route();
        return STS_NO_PATH;
    endfunction

    function automatic t_reply predict_reply(t_cmd c);
        t_reply rep;
        rep.status = STS_OK;
        rep.row    = '0;
        rep.col    = '0;
        rep.last   = 1'b0;
        case (c.action)
            ACT_WRITE: map_free[c.row * SIDE + c.col] = c.free;
            ACT_SEARCH: begin
                rep.status = plan_route(c.row, c.col, c.goal_row, c.goal_col);
                if (rep.status == STS_OK) routes_ok++;
                if (rep.status == STS_NO_PATH) routes_none++;
            end
            ACT_READ: begin
                if (c.index < route_n) begin
                    rep.row  = 6'(route[c.index] / SIDE);
                    rep.col  = 6'(route[c.index] % SIDE);
                    rep.last = (c.index + 1 == route_n);
                    reads_ok++;
                end else begin
                    rep.status = STS_BEYOND_PATH;
                end
            end
            default: ;
        endcase
        rep.found  = route_found;
        rep.length = 13'(route_n);
        rep.cost   = 21'(route_cost);
        return rep;
    endfunction

    // Driver: presents pending commands, with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_action     <= ACT_WRITE;
            i_cell_row   <= '0;
            i_cell_col   <= '0;
            i_cell_free  <= 1'b0;
            i_goal_row   <= '0;
            i_goal_col   <= '0;
            i_path_index <= '0;
            gap_left = 0;
        end else begin
            taken = start && !busy;
            if (taken) expected_replies.push_back(predict_reply(cur_cmd));
            if (start && !taken) begin
                // Hold the command until the core takes it.
            end else if (gap_left != 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].drain || expected_replies.size() == 0)) begin
                cur_cmd = pending_cmds.pop_front();
                start        <= 1'b1;
                i_action     <= cur_cmd.action;
                i_cell_row   <= cur_cmd.row;
                i_cell_col   <= cur_cmd.col;
                i_cell_free  <= cur_cmd.free;
                i_goal_row   <= cur_cmd.goal_row;
                i_goal_col   <= cur_cmd.goal_col;
                i_path_index <= cur_cmd.index;
                gap_left = $urandom_range(0, max_gap);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_reply exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run exceeded its cycle limit", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d", $time, o_status);
                errors++;
            end else begin
                exp_r = expected_replies.pop_front();
                if (o_status !== exp_r.status || o_path_found !== exp_r.found ||
                    o_path_length !== exp_r.length || o_path_cost !== exp_r.cost ||
                    o_out_row !== exp_r.row || o_out_col !== exp_r.col ||
                    o_last_entry !== exp_r.last) begin
                    $display("%0t: expected status %0d found %0d len %0d cost %0d row %0d col %0d last %0d",
                             $time, exp_r.status, exp_r.found, exp_r.length, exp_r.cost,
                             exp_r.row, exp_r.col, exp_r.last);
                    $display("%0t: actual   status %0d found %0d len %0d cost %0d row %0d col %0d last %0d",
                             $time, o_status, o_path_found, o_path_length, o_path_cost,
                             o_out_row, o_out_col, o_last_entry);
                    errors++;
                end
            end
        end
    end

    task automatic push_cmd(t_action a, int r, int c, int f, int gr, int gc, int idx);
        t_cmd cmd;
        cmd.action   = a;
        cmd.row      = 6'(r);
        cmd.col      = 6'(c);
        cmd.free     = f[0];
        cmd.goal_row = 6'(gr);
        cmd.goal_col = 6'(gc);
        cmd.index    = 12'(idx);
        cmd.drain    = ($urandom_range(0, 9) == 0);
        pending_cmds.push_back(cmd);
    endtask

    // Sampled at the falling edge, once every update of the rising edge has settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || expected_replies.size() != 0 || start || busy);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_diag(bit value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        diag_moves = value;
    endtask

    // One phase of random work inside the small free region, plus noise.
    task automatic random_phase(int count);
        int r;
        int c;
        int f;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                r = $urandom_range(0, REGION - 1);
                c = $urandom_range(0, REGION - 1);
                f = ($urandom_range(0, 9) < 7);
                plan_free[r][c] = f;
                push_cmd(ACT_WRITE, r, c, f, $urandom, $urandom, $urandom);
            end else if (pick < 32) begin
                // Far cells stay blocked so the region stays small.
                r = $urandom_range(REGION + 1, SIDE - 1);
                push_cmd(ACT_WRITE, r, $urandom_range(0, SIDE - 1), 0,
                         $urandom, $urandom, $urandom);
            end else if (pick < 60) begin
                push_cmd(ACT_SEARCH, $urandom_range(0, REGION - 1),
                         $urandom_range(0, REGION - 1), $urandom,
                         $urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
                         $urandom);
            end else if (pick < 65) begin
                push_cmd(ACT_SEARCH, $urandom_range(0, SIDE - 1),
                         $urandom_range(0, SIDE - 1), $urandom,
                         $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                         $urandom);
            end else if (pick < 90) begin
                push_cmd(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 12));
            end else if (pick < 96) begin
                push_cmd(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 4095));
            end else begin
                push_cmd(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            end
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        start       = 1'b0;
        diag_moves  = 1'b1;
        max_gap     = 14;
        gap_left    = 0;
        cycles      = 0;
        errors      = 0;
        routes_ok   = 0;
        routes_none = 0;
        reads_ok    = 0;
        drop_route();
        foreach (map_free[i]) map_free[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: far corner search, reads at the ends of the path, checks.
        push_cmd(ACT_WRITE, 63, 63, 1, 0, 0, 0);
        push_cmd(ACT_WRITE, 62, 62, 1, 63, 63, 4095);
        push_cmd(ACT_WRITE, 62, 63, 1, 0, 0, 0);
        push_cmd(ACT_SEARCH, 63, 63, 0, 62, 62, 0);
        push_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
        push_cmd(ACT_READ, 0, 0, 0, 0, 0, 1);
        push_cmd(ACT_READ, 0, 0, 0, 0, 0, 2);
        push_cmd(ACT_READ, 0, 0, 0, 0, 0, 4095);
        push_cmd(ACT_SEARCH, 62, 62, 0, 62, 62, 0);
        push_cmd(ACT_SEARCH, 63, 63, 0, 0, 0, 0);
        push_cmd(ACT_WRITE, 0, 0, 1, 0, 0, 0);
        push_cmd(ACT_WRITE, 0, 1, 1, 0, 0, 0);
        push_cmd(ACT_SEARCH, 0, 0, 1, 63, 63, 4095);
        push_cmd(ACT_NONE, 63, 63, 1, 63, 63, 4095);
        push_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
        push_cmd(ACT_SEARCH, 0, 1, 0, 0, 0, 0);
        push_cmd(ACT_READ, 0, 0, 0, 0, 0, 1);
        push_cmd(ACT_WRITE, 63, 63, 0, 0, 0, 0);
        push_cmd(ACT_WRITE, 62, 62, 0, 0, 0, 0);
        push_cmd(ACT_WRITE, 62, 63, 0, 0, 0, 0);
        wait_idle();

        // Open most of a small region, then run phases with both move sets.
        write_diag(1'b0);
        max_gap = 0;
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++) begin
                plan_free[r][c] = ($urandom_range(0, 9) < 8);
                push_cmd(ACT_WRITE, r, c, plan_free[r][c], 0, 0, 0);
            end
        random_phase(8);
        wait_idle();
        for (int ph = 0; ph < 4; ph++) begin
            write_diag(ph % 2 == 0);
            max_gap = (ph % 2 == 0) ? 14 : 0;
            random_phase(10);
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        $display("Covered %0d paths found, %0d unreachable goals, %0d path entries read,",
                 routes_ok, routes_none, reads_ok);
        $display("with diagonal moves on and off and random gaps between commands.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
